>>> rtl/tsag_pkg.sv
// Package for the tile sheet address generator: field widths, register
// indexes, reset values and clamp helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsag_pkg;

    // Field widths
    localparam int ROW_W      = 8;
    localparam int COL_W      = 8;
    localparam int FRAME_W    = 12;
    localparam int SRC_X_W    = 12;
    localparam int SRC_Y_W    = 28;
    localparam int DEST_W     = 16;

    // Register widths
    localparam int SHEET_W    = 13;
    localparam int TILE_W     = 9;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Offset (frame - 1) * tile width stays below 2^20
    localparam int OFFSET_W   = 20;

    // Register limits and reset values
    localparam logic [SHEET_W-1:0] SHEET_MAX   = 13'd4096;
    localparam logic [TILE_W-1:0]  TILE_MAX    = 9'd256;
    localparam logic [SHEET_W-1:0] SHEET_RESET = 13'd256;
    localparam logic [TILE_W-1:0]  TILE_RESET  = 9'd16;

    // Quotient bits resolved per divider stage
    localparam int TSAG_DIV_STEP = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHEET_WIDTH = 2'd0,
        CFG_TILE_WIDTH  = 2'd1,
        CFG_TILE_HEIGHT = 2'd2
    } t_cfg_index;

    // Divisor is held in 1..4096
    function automatic logic [SHEET_W-1:0] clamp_sheet(input logic [SHEET_W-1:0] v);
        logic [SHEET_W-1:0] r;
        if (v == '0) begin
            r = SHEET_W'(1);
        end else if (v > SHEET_MAX) begin
            r = SHEET_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Tile size is held in 0..256
    function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] r;
        if (v > TILE_MAX) begin
            r = TILE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tile_sheet_address_generator.sv
// Pipeline: entry register, DIV_STAGES divider stages of four quotient bits each by
// default, output register. Throughput: one request per cycle while the output is
// not stalled, set by the fully pipelined restoring divider; each stage holds its
// item until the next frees. Reset (synchronous, active low) empties every stage and
// loads the registers with sheet width 256, tile width 16 and tile height 16.
// Depends on tsag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tile_sheet_address_generator
    import tsag_pkg::*;
#(
    parameter int DIV_STEP = TSAG_DIV_STEP   // quotient bits per divider stage, 1..8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    // request channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [ROW_W-1:0]      i_map_row,
    input  wire logic [COL_W-1:0]      i_map_col,
    input  wire logic [FRAME_W-1:0]    i_frame_id,

    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_draw_tile,
    output logic [SRC_X_W-1:0]         o_source_x,
    output logic [SRC_Y_W-1:0]         o_source_y,
    output logic [DEST_W-1:0]          o_dest_x,
    output logic [DEST_W-1:0]          o_dest_y
);

    // Divider geometry: the offset is zero-padded on top to a whole number of
    // stages, which leaves the quotient unchanged.
    localparam int DIV_STAGES = (OFFSET_W + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W      = DIV_STAGES * DIV_STEP;
    localparam int REM_W      = SRC_X_W;   // remainder < divisor <= 4096

    typedef struct packed {
        logic               draw;
        logic [PAD_W-1:0]   num;    // dividend bits still to shift in, MSB first
        logic [REM_W-1:0]   rem;    // partial remainder
        logic [PAD_W-1:0]   quo;    // quotient bits so far
        logic [DEST_W-1:0]  dest_x;
        logic [DEST_W-1:0]  dest_y;
    } t_div_stage;

    // Resolve DIV_STEP quotient bits of one item: shift in a dividend bit,
    // compare against the divisor, subtract when it fits.
    function automatic t_div_stage div_step(input t_div_stage s,
                                            input logic [SHEET_W-1:0] d);
        t_div_stage         o;
        logic [REM_W:0]     ext;
        o = s;
        for (int j = 0; j < DIV_STEP; j++) begin
            ext   = {o.rem, o.num[PAD_W-1]};
            o.num = {o.num[PAD_W-2:0], 1'b0};
            if (ext >= (REM_W+1)'(d)) begin
                o.rem = REM_W'(ext - (REM_W+1)'(d));
                o.quo = {o.quo[PAD_W-2:0], 1'b1};
            end else begin
                o.rem = ext[REM_W-1:0];
                o.quo = {o.quo[PAD_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    //--------------------------------------------------------------------
    // Configuration registers, stored already clamped so the datapath sees
    // a divisor in 1..4096 and tile sizes in 0..256. Writes to an index
    // past the list drop.
    //--------------------------------------------------------------------
    logic [SHEET_W-1:0] r_div;
    logic [TILE_W-1:0]  r_tw;
    logic [TILE_W-1:0]  r_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= SHEET_RESET;
            r_tw  <= TILE_RESET;
            r_th  <= TILE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SHEET_WIDTH: r_div <= clamp_sheet(i_cfg_data);
                CFG_TILE_WIDTH:  r_tw  <= clamp_tile(i_cfg_data[TILE_W-1:0]);
                CFG_TILE_HEIGHT: r_th  <= clamp_tile(i_cfg_data[TILE_W-1:0]);
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Flow control. Stage 0 is the entry register, stages 1..DIV_STAGES are
    // the divider, then the output register. A stage advances when it is
    // empty or the stage after it advances, so bubbles collapse and the
    // pipe takes requests while a result waits at the output until it fills.
    //--------------------------------------------------------------------
    logic [DIV_STAGES:0] r_vld;
    t_div_stage          r_pipe [DIV_STAGES+1];
    logic [DIV_STAGES:0] stage_en;
    logic                out_en;
    logic                r_out_vld;

    assign out_en = !r_out_vld || !i_stall;

    always_comb begin
        stage_en[DIV_STAGES] = !r_vld[DIV_STAGES] || out_en;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[0];

    //--------------------------------------------------------------------
    // Stage 0: form the linear offset and both destination products.
    // For an empty cell the products are junk; the output masks them.
    //--------------------------------------------------------------------
    logic [FRAME_W-1:0]          frame_m1;
    logic [FRAME_W+TILE_W-1:0]   offset_full;
    logic [COL_W+TILE_W-1:0]     dx_full;
    logic [ROW_W+TILE_W-1:0]     dy_full;
    t_div_stage                  n_entry;

    always_comb begin
        frame_m1    = i_frame_id - FRAME_W'(1);
        offset_full = (FRAME_W+TILE_W)'(frame_m1) * (FRAME_W+TILE_W)'(r_tw);
        dx_full     = (COL_W+TILE_W)'(i_map_col) * (COL_W+TILE_W)'(r_tw);
        dy_full     = (ROW_W+TILE_W)'(i_map_row) * (ROW_W+TILE_W)'(r_th);

        n_entry        = '0;
        n_entry.draw   = (i_frame_id != '0);
        n_entry.num    = PAD_W'(offset_full[OFFSET_W-1:0]);
        n_entry.dest_x = dx_full[DEST_W-1:0];
        n_entry.dest_y = dy_full[DEST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (stage_en[0]) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0] && i_valid) begin
            r_pipe[0] <= n_entry;
        end
    end

    //--------------------------------------------------------------------
    // Divider stages: each resolves DIV_STEP quotient bits, MSB first.
    //--------------------------------------------------------------------
    for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
        t_div_stage n_stage;

        assign n_stage = div_step(r_pipe[g-1], r_div);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (stage_en[g]) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_en[g] && r_vld[g-1]) begin
                r_pipe[g] <= n_stage;
            end
        end
    end

    //--------------------------------------------------------------------
    // Output stage: scale the quotient by the tile height, zero every field
    // of an empty cell, and hold the result until the consumer takes it.
    //--------------------------------------------------------------------
    t_div_stage                 last;
    logic [OFFSET_W+TILE_W-1:0] sy_full;

    assign last    = r_pipe[DIV_STAGES];
    assign sy_full = (OFFSET_W+TILE_W)'(last.quo[OFFSET_W-1:0]) * (OFFSET_W+TILE_W)'(r_th);

    logic               r_draw;
    logic [SRC_X_W-1:0] r_sx;
    logic [SRC_Y_W-1:0] r_sy;
    logic [DEST_W-1:0]  r_dx;
    logic [DEST_W-1:0]  r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= r_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_vld[DIV_STAGES]) begin
            r_draw <= last.draw;
            r_sx   <= last.draw ? last.rem : '0;
            r_sy   <= last.draw ? sy_full[SRC_Y_W-1:0] : '0;
            r_dx   <= last.draw ? last.dest_x : '0;
            r_dy   <= last.draw ? last.dest_y : '0;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_draw_tile = r_draw;
    assign o_source_x  = r_sx;
    assign o_source_y  = r_sy;
    assign o_dest_x    = r_dx;
    assign o_dest_y    = r_dy;

endmodule

`default_nettype wire

>>> test/tb_tile_sheet_address_generator.sv
// Self-checking testbench for tile_sheet_address_generator: map cells with random
// handshake gaps and stalls, results checked against a local placement predictor.
// Depends on tsag_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_tile_sheet_address_generator;
    import tsag_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 14;     // longer than the pipeline depth of 7
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake on either side
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 7;
    localparam int CELLS_PER_PHASE = 250;

    localparam logic [FRAME_W-1:0]    FRAME_EMPTY = '0;
    localparam logic [FRAME_W-1:0]    FRAME_LAST  = '1;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED = 2'd3;  // no register behind it

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    // One predicted tile placement, laid out like the result port
    typedef struct packed {
        logic               draw;
        logic [SRC_X_W-1:0] src_x;
        logic [SRC_Y_W-1:0] src_y;
        logic [DEST_W-1:0]  dst_x;
        logic [DEST_W-1:0]  dst_y;
    } t_tile_place;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [ROW_W-1:0]      i_map_row;
    logic [COL_W-1:0]      i_map_col;
    logic [FRAME_W-1:0]    i_frame_id;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_draw_tile;
    logic [SRC_X_W-1:0]    o_source_x;
    logic [SRC_Y_W-1:0]    o_source_y;
    logic [DEST_W-1:0]     o_dest_x;
    logic [DEST_W-1:0]     o_dest_y;

    // Local copy of the register file, updated on every write we issue
    logic [SHEET_W-1:0] sheet_width_reg;
    logic [TILE_W-1:0]  tile_width_reg;
    logic [TILE_W-1:0]  tile_height_reg;

    t_tile_place  pending_places[$];
    int unsigned  cells_sent;
    int unsigned  places_checked;
    int unsigned  place_errors;
    int unsigned  reg_writes;
    int unsigned  idle_cycles;
    t_stall_mode  stall_mode;

    tile_sheet_address_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_map_row   (i_map_row),
        .i_map_col   (i_map_col),
        .i_frame_id  (i_frame_id),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_draw_tile (o_draw_tile),
        .o_source_x  (o_source_x),
        .o_source_y  (o_source_y),
        .o_dest_x    (o_dest_x),
        .o_dest_y    (o_dest_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Placement predictor. Works from the local register copy at the time
    // the request is accepted; writes only happen while nothing is in flight.
    // ------------------------------------------------------------------
    function automatic t_tile_place place_tile(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col,
                                               input logic [FRAME_W-1:0] frame);
        t_tile_place  p;
        int unsigned  divisor;
        int unsigned  tw;
        int unsigned  th;
        int unsigned  offset;
        p = '0;
        // Clamp the divisor into 1..4096; zero would divide by nothing
        if (sheet_width_reg == '0) begin
            divisor = 1;
        end else if (sheet_width_reg > SHEET_MAX) begin
            divisor = 32'(SHEET_MAX);
        end else begin
            divisor = 32'(sheet_width_reg);
        end
        // Tile sizes saturate at 256; zero stays zero
        tw = (tile_width_reg  > TILE_MAX) ? 32'(TILE_MAX) : 32'(tile_width_reg);
        th = (tile_height_reg > TILE_MAX) ? 32'(TILE_MAX) : 32'(tile_height_reg);
        // Empty cell: nothing drawn and every coordinate held at zero
        if (frame != FRAME_EMPTY) begin
            offset  = (32'(frame) - 1) * tw;
            p.draw  = 1'b1;
            p.src_x = SRC_X_W'(offset % divisor);
            p.src_y = SRC_Y_W'((offset / divisor) * th);
            p.dst_x = DEST_W'(32'(col) * tw);
            p.dst_y = DEST_W'(32'(row) * th);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tile_place seen;
        t_tile_place want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            seen = '{o_draw_tile, o_source_x, o_source_y, o_dest_x, o_dest_y};
            if (pending_places.size() == 0) begin
                place_errors++;
                if (place_errors <= REPORT_LIMIT) begin
                    $display("%0t: result with no request outstanding:", $realtime);
                    $display("    actual   draw=%0d sx=%0d sy=%0d dx=%0d dy=%0d",
                             seen.draw, seen.src_x, seen.src_y, seen.dst_x, seen.dst_y);
                end
            end else begin
                want = pending_places.pop_front();
                places_checked++;
                if (seen !== want) begin
                    place_errors++;
                    if (place_errors <= REPORT_LIMIT) begin
                        $display("%0t: result %0d mismatch", $realtime, places_checked);
                        $display("    expected draw=%0d sx=%0d sy=%0d dx=%0d dy=%0d",
                                 want.draw, want.src_x, want.src_y, want.dst_x, want.dst_y);
                        $display("    actual   draw=%0d sx=%0d sy=%0d dx=%0d dy=%0d",
                                 seen.draw, seen.src_x, seen.src_y, seen.dst_x, seen.dst_y);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // ------------------------------------------------------------------
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_places.size());
                $display("tile_sheet_address_generator verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: switch between stall patterns every so often,
    // including long stretches with no stall at all
    // ------------------------------------------------------------------
    initial begin
        int unsigned mode_left;
        int unsigned period;
        int unsigned phase;
        i_stall    = 1'b0;
        stall_mode = STALL_NONE;
        mode_left  = 0;
        period     = 2;
        phase      = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
                period     = $urandom_range(2, 5);
                phase      = 0;
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_LIGHT:    i_stall <= ($urandom_range(0, 99) < 25);
                STALL_HEAVY:    i_stall <= ($urandom_range(0, 99) < 75);
                STALL_PERIODIC: begin
                    i_stall <= (phase == 0);
                    phase = (phase + 1) % period;
                end
                default:        i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request side. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------

    // Offer one map cell, hold it until accepted, record the prediction
    task automatic send_cell(input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col,
                             input logic [FRAME_W-1:0] frame);
        i_valid    <= 1'b1;
        i_map_row  <= row;
        i_map_col  <= col;
        i_frame_id <= frame;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        pending_places.push_back(place_tile(row, col, frame));
        cells_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and let the sender idle; a zero argument leaves valid as it is
    task automatic idle_sender(input int unsigned cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Hold off until every prediction is matched, then let the pipe settle
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        while (pending_places.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register while the block is idle and mirror it locally
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (index)
            CFG_SHEET_WIDTH: sheet_width_reg = data[SHEET_W-1:0];
            CFG_TILE_WIDTH:  tile_width_reg  = data[TILE_W-1:0];
            CFG_TILE_HEIGHT: tile_height_reg = data[TILE_W-1:0];
            default:         ;  // unmapped index: block ignores it
        endcase
        reg_writes++;
    endtask

    task automatic write_all_regs(input logic [CFG_DATA_W-1:0] sheet,
                                  input logic [CFG_DATA_W-1:0] tw,
                                  input logic [CFG_DATA_W-1:0] th);
        write_reg(CFG_SHEET_WIDTH, sheet);
        write_reg(CFG_TILE_WIDTH, tw);
        write_reg(CFG_TILE_HEIGHT, th);
    endtask

    // Random map cell, biased toward empty cells and the frame extremes
    task automatic pick_cell(output logic [ROW_W-1:0] row,
                             output logic [COL_W-1:0] col,
                             output logic [FRAME_W-1:0] frame);
        int unsigned sel;
        sel   = $urandom_range(0, 99);
        row   = ROW_W'($urandom_range(0, 255));
        col   = COL_W'($urandom_range(0, 255));
        if (sel < 10) begin
            frame = FRAME_EMPTY;
        end else if (sel < 15) begin
            frame = FRAME_LAST;
        end else if (sel < 20) begin
            frame = FRAME_W'(1);
        end else begin
            frame = FRAME_W'($urandom_range(1, 4095));
        end
        if ($urandom_range(0, 19) == 0) row = '1;
        if ($urandom_range(0, 19) == 0) col = '1;
    endtask

    // Random register value: mostly legal, sometimes zero or past saturation
    function automatic logic [CFG_DATA_W-1:0] pick_sheet_width();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 13'd0;
            1:       return CFG_DATA_W'($urandom_range(4097, 8191));
            2, 3, 4: return CFG_DATA_W'($urandom_range(1, 64));
            default: return CFG_DATA_W'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_tile_size();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 13'd0;
            1:       return CFG_DATA_W'($urandom_range(257, 8191));  // high bits dropped
            2:       return 13'd256;
            default: return CFG_DATA_W'($urandom_range(1, 256));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 256-wide sheet, 16x16 tiles
    task automatic test_reset_values();
        send_cell(8'd255, 8'd255, FRAME_EMPTY);  // empty cell at the far corner
        send_cell(8'd0, 8'd0, 12'd1);            // first frame at origin
        send_cell(8'd3, 8'd7, 12'd16);           // last tile on the first sheet row
        send_cell(8'd9, 8'd4, 12'd17);           // wraps to the second sheet row
        send_cell(8'd255, 8'd255, FRAME_LAST);
    endtask

    // Register corners: zero and oversized sheet widths, zero and saturated
    // tile sizes, masked data bits and a write to an unmapped index
    task automatic test_register_extremes();
        write_reg(CFG_SHEET_WIDTH, 13'd0);       // divisor taken as 1
        send_cell(8'd1, 8'd2, 12'd5);
        send_cell(8'd0, 8'd0, FRAME_LAST);

        write_reg(CFG_SHEET_WIDTH, 13'h1FFF);    // divisor saturates at 4096
        send_cell(8'd10, 8'd20, 12'd300);
        send_cell(8'd255, 8'd0, FRAME_LAST);

        write_all_regs(13'd4096, 13'd256, 13'd256);
        send_cell(8'd255, 8'd255, FRAME_LAST);   // largest source y and destination
        send_cell(8'd128, 8'd1, 12'd17);

        write_all_regs(13'd100, 13'd0, 13'd0);   // zero-size tiles
        send_cell(8'd200, 8'd200, 12'd50);
        send_cell(8'd255, 8'd255, FRAME_EMPTY);

        write_all_regs(13'd1, 13'h1FFF, 13'h1F05); // 511 saturates, 0x105 saturates
        send_cell(8'd255, 8'd255, 12'd2);
        send_cell(8'd17, 8'd33, 12'd1000);

        write_all_regs(13'd4095, 13'h1E03, 13'd1); // tile width masks down to 3
        write_reg(CFG_UNMAPPED, 13'h1FFF);
        send_cell(8'd5, 8'd6, FRAME_LAST);
        send_cell(8'd255, 8'd128, 12'd2048);

        write_all_regs(13'd13, 13'd7, 13'd9);    // divisor that is not a power of two
        send_cell(8'd85, 8'd170, 12'd2730);
        send_cell(8'd170, 8'd85, 12'd1365);
    endtask

    // Random cells in bursts with random gaps, across several register settings.
    // Now and then the sender holds off until everything has come back.
    task automatic test_random_cells();
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [FRAME_W-1:0] frame;
        int unsigned        sent;
        int unsigned        burst;
        int unsigned        sel;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                write_all_regs(SHEET_RESET, CFG_DATA_W'(TILE_RESET),
                               CFG_DATA_W'(TILE_RESET));
            end else begin
                write_all_regs(pick_sheet_width(), pick_tile_size(), pick_tile_size());
            end
            sent = 0;
            while (sent < CELLS_PER_PHASE) begin
                burst = $urandom_range(1, 48);
                for (int k = 0; k < burst && sent < CELLS_PER_PHASE; k++) begin
                    pick_cell(row, col, frame);
                    send_cell(row, col, frame);
                    sent++;
                end
                sel = $urandom_range(0, 39);
                if (sel == 0) begin
                    wait_until_drained();
                end else if (sel < 14) begin
                    idle_sender(0);             // keep streaming
                end else begin
                    idle_sender($urandom_range(1, 8));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_SHEET_WIDTH;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_map_row   = '0;
        i_map_col   = '0;
        i_frame_id  = '0;
        cells_sent     = 0;
        places_checked = 0;
        place_errors   = 0;
        reg_writes     = 0;
        sheet_width_reg = SHEET_RESET;
        tile_width_reg  = TILE_RESET;
        tile_height_reg = TILE_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_register_extremes();
        test_random_cells();
        wait_until_drained();

        $display("covered %0d map cells over %0d register writes, %0d placements compared",
                 cells_sent, reg_writes, places_checked);
        $display("mismatches %0d, predictions left unmatched %0d",
                 place_errors, pending_places.size());
        if (place_errors == 0 && pending_places.size() == 0) begin
            $display("tile_sheet_address_generator verification clean");
        end else begin
            $display("tile_sheet_address_generator verification failed");
        end
        $finish;
    end

endmodule
